@@ rtl/core/sads_pkg.sv @@
// ----------------------------------------------------------------------------
// sads_pkg
// Shared types and constants for the shared-array double stack unit.
// ----------------------------------------------------------------------------
package sads_pkg;

	// store geometry
	localparam int STORE_DEPTH = 16;
	localparam int WORD_WIDTH  = 32;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int PTR_W       = $clog2(STORE_DEPTH + 1);
	localparam int FIELD_W     = 32;

	// answer for a pop or peek on an empty side
	localparam logic signed [FIELD_W-1:0] EMPTY_WORD = FIELD_W'(-999);

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_CLEAR = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// one input item
	typedef struct packed {
		command_t                   command;
		logic                       side;
		logic signed [FIELD_W-1:0] push_value;
	} request_t;

	// one result item
	typedef struct packed {
		logic signed [FIELD_W-1:0] read_value;
		status_t                    status;
		logic                       is_full;
		logic                       lower_empty;
		logic                       upper_empty;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic execute;
		logic finish;
	} ctl_cmd_t;

endpackage

@@ rtl/core/sads_ram.sv @@
// ----------------------------------------------------------------------------
// sads_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sads_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/sads_ctrl.sv @@
// ----------------------------------------------------------------------------
// sads_ctrl
// Sequencer: accept an item, execute it against the store, deliver the result.
// ----------------------------------------------------------------------------
module sads_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output sads_pkg::ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		IDLE,
		EXEC,
		FINISH
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	// state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= EXEC;
						busy_q  <= 1'b1;
					end
				end
				EXEC: begin
					state_q <= FINISH;
				end
				FINISH: begin
					state_q <= IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// datapath commands
	always_comb begin
		cmd.capture = (state_q == IDLE) && start;
		cmd.execute = (state_q == EXEC);
		cmd.finish  = (state_q == FINISH);
	end

	assign busy = busy_q;
	assign done = done_q;

	// busy tracks the state
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != IDLE))
		else $error("busy does not match controller state");

	// result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held longer than one cycle");

	// every accepted item yields a result
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |-> ##3 done_q)
		else $error("accepted item produced no result");

endmodule

@@ rtl/core/sads_dp.sv @@
// ----------------------------------------------------------------------------
// sads_dp
// Datapath: item register, stack pointers, word store and result register.
// ----------------------------------------------------------------------------
module sads_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  sads_pkg::ctl_cmd_t cmd,
	input  sads_pkg::request_t request,
	output sads_pkg::result_t  result
);

	localparam logic [sads_pkg::PTR_W-1:0] DEPTH_PTR =
		sads_pkg::PTR_W'(sads_pkg::STORE_DEPTH);

	sads_pkg::request_t              req_q;
	logic [sads_pkg::PTR_W-1:0]      lower_q;
	logic [sads_pkg::PTR_W-1:0]      upper_q;
	logic [sads_pkg::PTR_W-1:0]      lower_d;
	logic [sads_pkg::PTR_W-1:0]      upper_d;
	sads_pkg::status_t               status_q;
	sads_pkg::status_t               status_d;
	logic                            read_q;
	logic                            read_d;
	sads_pkg::result_t               result_q;
	logic                            full;
	logic                            side_empty;
	logic                            ram_we;
	logic [sads_pkg::PTR_W-1:0]      ram_ptr;
	logic [sads_pkg::WORD_WIDTH-1:0] ram_wdata;
	logic [sads_pkg::WORD_WIDTH-1:0] ram_rdata;

	// item register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= request;
		end
	end

	assign full       = (lower_q >= upper_q);
	assign side_empty = req_q.side ? (upper_q == DEPTH_PTR) : (lower_q == '0);
	assign ram_wdata  = sads_pkg::WORD_WIDTH'(req_q.push_value);

	// command decode and pointer update
	always_comb begin
		lower_d  = lower_q;
		upper_d  = upper_q;
		status_d = sads_pkg::ST_OK;
		read_d   = 1'b0;
		ram_we   = 1'b0;
		ram_ptr  = lower_q;
		case (req_q.command)
			sads_pkg::CMD_CLEAR: begin
				lower_d = '0;
				upper_d = DEPTH_PTR;
			end
			sads_pkg::CMD_PUSH: begin
				if (full) begin
					status_d = sads_pkg::ST_FULL;
				end else if (!req_q.side) begin
					ram_we  = 1'b1;
					ram_ptr = lower_q;
					lower_d = lower_q + 1'b1;
				end else begin
					ram_we  = 1'b1;
					ram_ptr = upper_q - 1'b1;
					upper_d = upper_q - 1'b1;
				end
			end
			sads_pkg::CMD_POP, sads_pkg::CMD_PEEK: begin
				if (side_empty) begin
					status_d = sads_pkg::ST_EMPTY;
				end else if (!req_q.side) begin
					read_d  = 1'b1;
					ram_ptr = lower_q - 1'b1;
					if (req_q.command == sads_pkg::CMD_POP) begin
						lower_d = lower_q - 1'b1;
					end
				end else begin
					read_d  = 1'b1;
					ram_ptr = upper_q;
					if (req_q.command == sads_pkg::CMD_POP) begin
						upper_d = upper_q + 1'b1;
					end
				end
			end
			default: begin
				status_d = sads_pkg::ST_OK;
			end
		endcase
	end

	// stack pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= DEPTH_PTR;
		end else if (cmd.execute) begin
			lower_q <= lower_d;
			upper_q <= upper_d;
		end
	end

	// outcome of the executed item
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q <= status_d;
			read_q   <= read_d;
		end
	end

	sads_ram #(
		.WIDTH (sads_pkg::WORD_WIDTH),
		.DEPTH (sads_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.execute && ram_we),
		.addr  (ram_ptr[sads_pkg::ADDR_W-1:0]),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// result register, flags from the updated pointers
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (status_q == sads_pkg::ST_EMPTY) begin
				result_q.read_value <= sads_pkg::EMPTY_WORD;
			end else if (read_q) begin
				result_q.read_value <= sads_pkg::FIELD_W'(signed'(ram_rdata));
			end else begin
				result_q.read_value <= '0;
			end
			result_q.status      <= status_q;
			result_q.is_full     <= (lower_q >= upper_q);
			result_q.lower_empty <= (lower_q == '0);
			result_q.upper_empty <= (upper_q == DEPTH_PTR);
		end
	end

	assign result = result_q;

	// the two stacks never cross
	a_no_cross: assert property (@(posedge clk) disable iff (!arst_n)
		lower_q <= upper_q)
		else $error("stack pointers crossed");

	// upper base stays inside the store
	a_upper_range: assert property (@(posedge clk) disable iff (!arst_n)
		upper_q <= DEPTH_PTR)
		else $error("upper base beyond store");

	// pointers move only while an item executes
	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.execute |=> ($stable(lower_q) && $stable(upper_q)))
		else $error("pointer changed outside execute");

endmodule

@@ rtl/core/shared_array_double_stack_unit.sv @@
// ----------------------------------------------------------------------------
// shared_array_double_stack_unit
// Two stacks in one word store: lower grows up, upper grows down.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. EXEC executes it against
// the pointers and issues the store access, FINISH loads the store's registered
// read into the result register, and the result is then shown with done high
// for exactly one cycle, the same cycle busy drops, so a new item can be taken
// in that cycle. The receiver cannot stall; done is a one-cycle strobe and the
// result ports must be captured while it is high. Push on a full store
// answers status full, pop or peek on an empty side answers -999 with status
// empty; clear empties both stacks without touching the stored words.
module shared_array_double_stack_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sads_pkg::request_t request,
	output logic               done,
	output sads_pkg::result_t  result
);

	sads_pkg::ctl_cmd_t cmd;

	// sequencer
	sads_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// pointers, store and result
	sads_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.result  (result)
	);

endmodule
